// ----- sv/egcd_pkg.sv -----
// ----------------------------------------------------------------------------
// egcd_pkg
// Types, widths and the control program shared by the extended GCD unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

    localparam int OPND_W  = 31;
    localparam int COEF_W  = 32;
    localparam int DIV_W   = OPND_W + 1;
    localparam int SHIFT_W = $clog2(OPND_W);

    typedef struct packed {
        logic [OPND_W-1:0] a_value;
        logic [OPND_W-1:0] b_value;
    } egcd_in_t;

    typedef struct packed {
        logic [OPND_W-1:0]        divisor;
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
    } egcd_out_t;

    // Datapath operation selected by the current control word.
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ALIGN,
        OP_REDUCE,
        OP_EMIT
    } op_t;

    // Branch conditions the sequencer can test.
    typedef enum logic [2:0] {
        C_NEVER,
        C_IN_VALID,
        C_RC_ZERO,
        C_FITS_NEXT,
        C_K_ZERO,
        C_OUT_FREE
    } cond_t;

    typedef logic [1:0] step_t;

    localparam step_t STEP_WAIT   = 2'd0;
    localparam step_t STEP_ALIGN  = 2'd1;
    localparam step_t STEP_REDUCE = 2'd2;
    localparam step_t STEP_EMIT   = 2'd3;

    typedef struct packed {
        op_t   op;
        cond_t cond1;
        step_t jump1;
        cond_t cond2;
        step_t jump2;
        step_t next;
    } ctrl_word_t;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic rc_zero;
        logic fits_next;
        logic k_zero;
        logic out_free;
    } egcd_status_t;

    // The program: first matching condition wins, otherwise fall to next.
    localparam ctrl_word_t MICROCODE [0:3] = '{
        '{op: OP_LOAD,   cond1: C_IN_VALID, jump1: STEP_ALIGN,
          cond2: C_NEVER,     jump2: STEP_WAIT,  next: STEP_WAIT},
        '{op: OP_ALIGN,  cond1: C_RC_ZERO,  jump1: STEP_EMIT,
          cond2: C_FITS_NEXT, jump2: STEP_ALIGN, next: STEP_REDUCE},
        '{op: OP_REDUCE, cond1: C_K_ZERO,   jump1: STEP_ALIGN,
          cond2: C_NEVER,     jump2: STEP_WAIT,  next: STEP_REDUCE},
        '{op: OP_EMIT,   cond1: C_OUT_FREE, jump1: STEP_WAIT,
          cond2: C_NEVER,     jump2: STEP_WAIT,  next: STEP_EMIT}
    };

endpackage

// ----- sv/egcd_sequencer.sv -----
// ----------------------------------------------------------------------------
// egcd_sequencer
// Step counter and control store that drive the extended GCD datapath.
// ----------------------------------------------------------------------------
module egcd_sequencer import egcd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  egcd_status_t status,
    output ctrl_word_t   ctrl
);

    step_t step_reg, step_next;
    logic  hit1, hit2;

    function automatic logic cond_met(input cond_t c, input egcd_status_t s);
        logic r;
        unique case (c)
            C_NEVER:     r = 1'b0;
            C_IN_VALID:  r = s.in_valid;
            C_RC_ZERO:   r = s.rc_zero;
            C_FITS_NEXT: r = s.fits_next;
            C_K_ZERO:    r = s.k_zero;
            C_OUT_FREE:  r = s.out_free;
            default:     r = 1'b0;
        endcase
        return r;
    endfunction

    // Output block: the control word of the current step.
    always_comb begin
        ctrl = MICROCODE[step_reg];
    end

    // Next-step block.
    always_comb begin
        hit1 = cond_met(ctrl.cond1, status);
        hit2 = cond_met(ctrl.cond2, status);
        priority if (hit1) begin
            step_next = ctrl.jump1;
        end else if (hit2) begin
            step_next = ctrl.jump2;
        end else begin
            step_next = ctrl.next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- sv/extended_gcd_unit.sv -----
// ----------------------------------------------------------------------------
// extended_gcd_unit
// Greatest common divisor with Bezout coefficients, microprogrammed.
// ----------------------------------------------------------------------------
// Usage:
// A request on s_ (s_valid/s_ready, payload s_data) carries operands a and b.
// The result on m_ (m_valid/m_ready, payload m_data) carries g = gcd(a, b) and
// coefficients x, y with a*x + b*y = g; b = 0 gives g = a, x = 1, y = 0.
// One request is worked on at a time. Each Euclid step divides by restoring
// long division in the coefficient domain as well: the divisor is shifted up
// until it would pass the remainder, then it is shifted back down, subtracted
// wherever it fits; at the lowest bit the remainder becomes the new divisor.
// s_ready is high only while the sequencer waits for a new request, and the
// result sits in an output register: once it is loaded the next request is
// taken even while m_valid waits for m_ready. If the result register is still
// full when a new result is ready, the sequencer holds until it is taken.
// Reset (aresetn low, synchronous) returns the sequencer to its wait step and
// clears m_valid; a request in progress is dropped.
// ----------------------------------------------------------------------------
module extended_gcd_unit import egcd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  egcd_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output egcd_out_t m_data
);

    ctrl_word_t   ctrl;
    egcd_status_t status;

    logic [OPND_W-1:0]        rp_reg, rp_next, rc_reg, rc_next;
    logic signed [COEF_W-1:0] xp_reg, xp_next, xc_reg, xc_next;
    logic signed [COEF_W-1:0] yp_reg, yp_next, yc_reg, yc_next;
    logic [SHIFT_W-1:0]       k_reg, k_next;
    logic                     m_valid_reg, m_valid_next;
    egcd_out_t                m_data_reg, m_data_next;

    logic [DIV_W-1:0]         sh_r;
    logic signed [COEF_W-1:0] sh_x, sh_y;
    logic                     fits_now, fits_next;
    logic [OPND_W-1:0]        r_rem;
    logic signed [COEF_W-1:0] x_rem, y_rem;
    logic                     out_free;

    egcd_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    // Divisor and its coefficients scaled by 2^k. The divisor is shifted up only
    // while its double still fits under the remainder, so DIV_W bits always hold it.
    assign sh_r = {1'b0, rc_reg} << k_reg;
    assign sh_x = xc_reg << k_reg;
    assign sh_y = yc_reg << k_reg;

    assign fits_now  = sh_r <= {1'b0, rp_reg};
    assign fits_next = {sh_r, 1'b0} <= {2'b00, rp_reg};

    assign r_rem = fits_now ? (rp_reg - sh_r[OPND_W-1:0]) : rp_reg;
    assign x_rem = fits_now ? (xp_reg - sh_x) : xp_reg;
    assign y_rem = fits_now ? (yp_reg - sh_y) : yp_reg;

    assign out_free = !m_valid_reg || m_ready;

    assign status.in_valid  = s_valid;
    assign status.rc_zero   = (rc_reg == '0);
    assign status.fits_next = fits_next;
    assign status.k_zero    = (k_reg == '0);
    assign status.out_free  = out_free;

    assign s_ready = (ctrl.op == OP_LOAD);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        rp_next      = rp_reg;
        rc_next      = rc_reg;
        xp_next      = xp_reg;
        xc_next      = xc_reg;
        yp_next      = yp_reg;
        yc_next      = yc_reg;
        k_next       = k_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (ctrl.op)
            OP_LOAD: begin
                if (s_valid) begin
                    rp_next = s_data.a_value;
                    rc_next = s_data.b_value;
                    xp_next = COEF_W'(1);
                    xc_next = '0;
                    yp_next = '0;
                    yc_next = COEF_W'(1);
                    k_next  = '0;
                end
            end
            OP_ALIGN: begin
                if (!status.rc_zero && fits_next) begin
                    k_next = k_reg + SHIFT_W'(1);
                end
            end
            OP_REDUCE: begin
                if (k_reg == '0) begin
                    // Last quotient bit: the remainder becomes the new divisor.
                    rp_next = rc_reg;
                    rc_next = r_rem;
                    xp_next = xc_reg;
                    xc_next = x_rem;
                    yp_next = yc_reg;
                    yc_next = y_rem;
                end else begin
                    rp_next = r_rem;
                    xp_next = x_rem;
                    yp_next = y_rem;
                    k_next  = k_reg - SHIFT_W'(1);
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_data_next.divisor = rp_reg;
                    m_data_next.coef_a  = xp_reg;
                    m_data_next.coef_b  = yp_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rp_reg     <= rp_next;
        rc_reg     <= rc_next;
        xp_reg     <= xp_next;
        xc_reg     <= xc_next;
        yp_reg     <= yp_next;
        yc_reg     <= yc_next;
        k_reg      <= k_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ----- sv/egcd_checker.sv -----
// ----------------------------------------------------------------------------
// egcd_checker
// Port-level checks for the extended GCD unit, bound to its top level.
// ----------------------------------------------------------------------------
module egcd_checker import egcd_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input egcd_out_t m_data
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    // Only one request is in work: a taken request is never followed back to back by another.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken back to back");

    // A zero divisor comes only from two zero operands, with x = 1 and y = 0.
    a_zero_case: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.divisor == '0) |->
            (m_data.coef_a == COEF_W'(1)) && (m_data.coef_b == '0))
        else $error("wrong coefficients for zero operands");

endmodule

bind extended_gcd_unit egcd_checker u_egcd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/extended_gcd_unit_tb.sv -----
// ----------------------------------------------------------------------------
// extended_gcd_unit_tb
// Self-checking bench for the extended GCD unit. Operand requests are queued
// by an initial block and driven with random gaps. A monitor predicts the
// gcd and Bezout coefficients of every accepted request and compares them
// with each result taken under random back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module extended_gcd_unit_tb import egcd_pkg::*; ();

    localparam int                CLK_HALF     = 6;
    localparam int                RESET_CYCLES = 11;
    localparam int                RANDOM_REQS  = 1130;
    localparam int                DRAIN_CYCLES = 400;
    localparam int                CYCLE_LIMIT  = 1500000;
    localparam logic [OPND_W-1:0] OPND_MAX     = '1;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    egcd_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    egcd_out_t m_data;

    egcd_in_t  operand_queue[$];
    egcd_out_t bezout_expected[$];
    logic      req_taken = 1'b0;
    int        error_count = 0;

    extended_gcd_unit u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Iterative extended Euclid: the coefficient pairs follow the remainders.
    function automatic egcd_out_t bezout_of(egcd_in_t req);
        longint    r_prev, r_cur, x_prev, x_cur, y_prev, y_cur, q, t;
        egcd_out_t res;
        r_prev = longint'(req.a_value);
        r_cur  = longint'(req.b_value);
        x_prev = 1;
        x_cur  = 0;
        y_prev = 0;
        y_cur  = 1;
        while (r_cur != 0) begin
            q      = r_prev / r_cur;
            t      = r_prev - q * r_cur;
            r_prev = r_cur;
            r_cur  = t;
            t      = x_prev - q * x_cur;
            x_prev = x_cur;
            x_cur  = t;
            t      = y_prev - q * y_cur;
            y_prev = y_cur;
            y_cur  = t;
        end
        res.divisor = r_prev[OPND_W-1:0];
        res.coef_a  = x_prev[COEF_W-1:0];
        res.coef_b  = y_prev[COEF_W-1:0];
        return res;
    endfunction

    // Idle length: mostly short, now and then long, zero during a burst.
    function automatic int idle_len(bit burst);
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 45) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    function automatic egcd_in_t make_request(logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
        egcd_in_t req;
        req.a_value = a;
        req.b_value = b;
        return req;
    endfunction

    // Random operands of several shapes, so that both short and long
    // remainder chains are exercised.
    function automatic egcd_in_t random_request();
        logic [OPND_W-1:0] a, b, g;
        longint            fib_lo, fib_hi, t;
        int                kind, steps;
        kind = $urandom_range(0, 99);
        a    = OPND_W'($urandom());
        b    = OPND_W'($urandom());
        if (kind < 35) begin
            // full range as drawn
        end else if (kind < 50) begin
            a = OPND_W'($urandom_range(0, 255));
            b = OPND_W'($urandom_range(0, 255));
        end else if (kind < 65) begin
            // Shared factor, so that the divisor is a multiple of it.
            g = OPND_W'($urandom_range(1, 1 << $urandom_range(0, 15)));
            a = OPND_W'(g * $urandom_range(0, int'(OPND_MAX / g)));
            b = OPND_W'(g * $urandom_range(0, int'(OPND_MAX / g)));
        end else if (kind < 75) begin
            // Consecutive Fibonacci numbers give the longest chains.
            steps  = $urandom_range(1, 44);
            fib_lo = 1;
            fib_hi = 1;
            for (int i = 0; i < steps; i++) begin
                t      = fib_lo + fib_hi;
                fib_lo = fib_hi;
                fib_hi = t;
            end
            a = fib_hi[OPND_W-1:0];
            b = fib_lo[OPND_W-1:0];
            if ($urandom_range(0, 1) == 1) begin
                a = fib_lo[OPND_W-1:0];
                b = fib_hi[OPND_W-1:0];
            end
        end else if (kind < 85) begin
            if ($urandom_range(0, 1) == 1) begin
                a = '0;
            end else begin
                b = '0;
            end
        end else if (kind < 90) begin
            b = a;
        end else begin
            a = a >> $urandom_range(0, OPND_W - 1);
            b = b >> $urandom_range(0, OPND_W - 1);
        end
        return make_request(a, b);
    endfunction

    // Request driver.
    int gap_left = 0;
    bit req_burst = 1'b0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_taken) begin
            // hold the request until it is taken
        end else if (gap_left > 0) begin
            s_valid  <= 1'b0;
            gap_left = gap_left - 1;
        end else if (operand_queue.size() > 0) begin
            s_data  <= operand_queue.pop_front();
            s_valid <= 1'b1;
            if ($urandom_range(0, 99) < 3) begin
                req_burst = !req_burst;
            end
            gap_left = idle_len(req_burst);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result back-pressure.
    int stall_left = 0;
    bit res_burst = 1'b0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 199) < 3) begin
                res_burst = !res_burst;
            end
            if ($urandom_range(0, 99) < 30) begin
                stall_left = idle_len(res_burst);
            end
        end
    end

    // Monitor: predict on each accepted request, check each accepted result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                bezout_expected.push_back(bezout_of(s_data));
            end
            if (m_valid && m_ready) begin
                if (bezout_expected.size() == 0) begin
                    $error("result with no request pending: divisor %0d",
                           m_data.divisor);
                    error_count++;
                end else begin
                    egcd_out_t want;
                    want = bezout_expected.pop_front();
                    if (m_data.divisor !== want.divisor) begin
                        $error("divisor: expected %0d, got %0d",
                               want.divisor, m_data.divisor);
                        error_count++;
                    end
                    if (m_data.coef_a !== want.coef_a) begin
                        $error("coef_a: expected %0d, got %0d",
                               want.coef_a, m_data.coef_a);
                        error_count++;
                    end
                    if (m_data.coef_b !== want.coef_b) begin
                        $error("coef_b: expected %0d, got %0d",
                               want.coef_b, m_data.coef_b);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("extended_gcd_unit_tb: FAIL");
        $finish;
    end

    initial begin
        // Directed: zeros, extremes, equal operands and worst-case chains.
        operand_queue.push_back(make_request('0, '0));
        operand_queue.push_back(make_request(31'd12345, '0));
        operand_queue.push_back(make_request('0, 31'd6789));
        operand_queue.push_back(make_request(OPND_MAX, '0));
        operand_queue.push_back(make_request('0, OPND_MAX));
        operand_queue.push_back(make_request(31'd1, '0));
        operand_queue.push_back(make_request('0, 31'd1));
        operand_queue.push_back(make_request(31'd1, 31'd1));
        operand_queue.push_back(make_request(OPND_MAX, OPND_MAX));
        operand_queue.push_back(make_request(OPND_MAX, OPND_MAX - 31'd1));
        operand_queue.push_back(make_request(OPND_MAX - 31'd1, OPND_MAX));
        operand_queue.push_back(make_request(OPND_MAX, 31'd1));
        operand_queue.push_back(make_request(31'd1, OPND_MAX));
        operand_queue.push_back(make_request(31'd1836311903, 31'd1134903170));
        operand_queue.push_back(make_request(31'd1134903170, 31'd1836311903));
        operand_queue.push_back(make_request(31'd1134903170, 31'd701408733));
        operand_queue.push_back(make_request(OPND_MAX, 31'h4000_0000));
        operand_queue.push_back(make_request(31'h4000_0000, 31'h2000_0000));
        operand_queue.push_back(make_request(31'h5555_5555, 31'h2AAA_AAAA));
        operand_queue.push_back(make_request(31'd240, 31'd46));
        operand_queue.push_back(make_request(31'd46, 31'd240));
        operand_queue.push_back(make_request(31'd17, 31'd17));
        for (int i = 0; i < RANDOM_REQS; i++) begin
            operand_queue.push_back(random_request());
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (operand_queue.size() > 0 || s_valid) @(posedge aclk);
        while (bezout_expected.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("extended_gcd_unit_tb: PASS");
        end else begin
            $display("extended_gcd_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
